>>> hw/rtl/ctl_pkg.sv
// Shared constants, result record and character-class helpers for the config text lexer.
package ctl_pkg;

  localparam int POS_BITS   = 16;
  localparam int VALUE_BITS = 64;

  localparam logic [POS_BITS-1:0]   POS_MAX = '1;
  localparam logic [VALUE_BITS-1:0] VAL_CAP = {1'b1, {(VALUE_BITS - 1){1'b0}}};

  // Token kinds
  localparam logic [2:0] KIND_IDENT  = 3'd0;
  localparam logic [2:0] KIND_NUMBER = 3'd1;
  localparam logic [2:0] KIND_STRING = 3'd2;
  localparam logic [2:0] KIND_COMMA  = 3'd3;
  localparam logic [2:0] KIND_COLON  = 3'd4;
  localparam logic [2:0] KIND_EQUALS = 3'd5;
  localparam logic [2:0] KIND_END    = 3'd6;
  localparam logic [2:0] KIND_ERROR  = 3'd7;

  // Error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_EOF_STRING = 3'd1;
  localparam logic [2:0] ERR_NL_STRING  = 3'd2;
  localparam logic [2:0] ERR_BAD_START  = 3'd3;
  localparam logic [2:0] ERR_BAD_NUMBER = 3'd4;

  // Characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  error_code;
    logic [15:0] token_line;
    logic [15:0] token_col;
    logic [15:0] token_length;
    logic [63:0] number_value;
    logic        last;
  } result_t;

  function automatic logic is_space(input logic [7:0] c);
    return c inside {8'h20, [8'h09:8'h0D]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic logic is_dec(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    return (c inside {CH_RPAR, CH_COMMA, CH_EQ, CH_COLON}) || is_space(c);
  endfunction

  function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
    return (v == POS_MAX) ? POS_MAX : v + 1'b1;
  endfunction

  // Decode one digit; bit 4 flags a valid digit for the radix
  function automatic logic [4:0] digit_decode(input logic [7:0] c, input logic hex);
    logic [4:0] r;
    r = 5'd0;
    if (is_dec(c)) begin
      r = {1'b1, 4'(c - CH_ZERO)};
    end else if (hex && (c inside {[8'h61:8'h66]})) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (hex && (c inside {[8'h41:8'h46]})) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic result_t make_res(input logic [2:0] kind, input logic [2:0] err,
                                       input logic [POS_BITS-1:0] line,
                                       input logic [POS_BITS-1:0] col,
                                       input logic [POS_BITS-1:0] len,
                                       input logic [63:0] val);
    result_t r;
    r.kind         = kind;
    r.error_code   = err;
    r.token_line   = 16'(line);
    r.token_col    = 16'(col);
    r.token_length = 16'(len);
    r.number_value = val;
    r.last         = 1'b0;
    return r;
  endfunction

endpackage

>>> hw/rtl/config_text_lexer_top.sv
// Config text lexer: byte-stream tokenizer with line/column tracking and a result queue.
//
// Usage: feed one source byte per request on the in_ channel (in_ch, or
// in_end_of_input to close the source). Each token found comes out as one
// request on the out_ channel with kind, error code, start line/column,
// length and number value; out_last marks the final result of a byte.
// A byte can give zero, one or two results.
// A result is written to the result queue when the byte that causes it is
// accepted and is presented from there. Throughput: one byte per cycle while
// in_stall is low; the scan state is updated in a single pass as each byte is accepted.
// The results go into a four-entry queue; in_stall rises while fewer than two
// entries are free, so a stalled receiver backs up into the input channel
// once three results are waiting; bytes that give no result are held as well.
// Results hold steady while out_stall is high.
// After an end or error result the block ignores all further bytes.
// Reset (rst_n low, synchronous) returns the scanner to line 1, column 1 with
// no token open and empties the result queue.
module config_text_lexer_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_ch,
  input  logic                        in_end_of_input,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  out_kind,
  output logic [2:0]                  out_error_code,
  output logic [15:0]                 out_token_line,
  output logic [15:0]                 out_token_col,
  output logic [15:0]                 out_token_length,
  output logic signed [63:0]          out_number_value,
  output logic                        out_last
);
  import ctl_pkg::*;

  localparam logic [2:0] M_IDLE      = 3'd0;
  localparam logic [2:0] M_IDENT     = 3'd1;
  localparam logic [2:0] M_STRING    = 3'd2;
  localparam logic [2:0] M_NUM_FIRST = 3'd3;
  localparam logic [2:0] M_NUM       = 3'd4;
  localparam logic [2:0] M_HEX_SIGN  = 3'd5;
  localparam logic [2:0] M_HALT      = 3'd6;

  localparam int QDEPTH = 4;
  localparam int QPTR   = $clog2(QDEPTH);
  localparam int WIDE   = VALUE_BITS + 5;

  logic [2:0]            mode_r, mode_nxt;
  logic                  first_r, first_nxt;
  logic                  comment_r, comment_nxt;
  logic                  cr_r, cr_nxt;
  logic [POS_BITS-1:0]   line_r, line_nxt;
  logic [POS_BITS-1:0]   col_r, col_nxt;
  logic [POS_BITS-1:0]   sline_r, sline_nxt;
  logic [POS_BITS-1:0]   scol_r, scol_nxt;
  logic [POS_BITS-1:0]   tlen_r, tlen_nxt;
  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  logic                  neg_r, neg_nxt;
  logic                  hex_r, hex_nxt;
  logic                  dseen_r, dseen_nxt;
  logic                  nvalid_r, nvalid_nxt;

  result_t               queue_r [QDEPTH];
  logic [QPTR-1:0]       head_r, tail_r;
  logic [QPTR:0]         cnt_r;

  logic                  in_acc, out_acc;
  result_t               res [2];
  logic [1:0]            n_res;
  logic                  do_finish, do_start, eoi_end;

  // Digit accumulate with saturation at the magnitude cap
  logic [4:0]            dig;
  logic [WIDE-1:0]       m_ext, prod, acc_sum;
  logic [VALUE_BITS-1:0] mag_digit;
  logic [VALUE_BITS-1:0] num_val;
  logic [63:0]           num_val64;

  assign dig       = digit_decode(in_ch, hex_r);
  assign m_ext     = WIDE'(mag_r);
  assign prod      = hex_r ? (m_ext << 4) : ((m_ext << 3) + (m_ext << 1));
  assign acc_sum   = prod + WIDE'(dig[3:0]);
  assign mag_digit = (acc_sum > WIDE'(VAL_CAP)) ? VAL_CAP : acc_sum[VALUE_BITS-1:0];

  // Signed value of the open number, clamped on the positive side
  assign num_val   = neg_r ? (VALUE_BITS'(0) - mag_r)
                           : ((mag_r < VAL_CAP) ? mag_r : VAL_CAP - 1'b1);
  assign num_val64 = 64'(signed'(num_val));

  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;
  assign in_stall  = (cnt_r > (QPTR + 1)'(QDEPTH - 2));

  // Scan one byte: state update and up to two results
  always_comb begin
    mode_nxt    = mode_r;
    first_nxt   = first_r;
    comment_nxt = comment_r;
    cr_nxt      = cr_r;
    line_nxt    = line_r;
    col_nxt     = col_r;
    sline_nxt   = sline_r;
    scol_nxt    = scol_r;
    tlen_nxt    = tlen_r;
    mag_nxt     = mag_r;
    neg_nxt     = neg_r;
    hex_nxt     = hex_r;
    dseen_nxt   = dseen_r;
    nvalid_nxt  = nvalid_r;
    res[0]      = '0;
    res[1]      = '0;
    n_res       = 2'd0;
    do_finish   = 1'b0;
    do_start    = 1'b0;
    eoi_end     = 1'b0;

    if (in_acc && mode_r != M_HALT) begin
      if (cr_r && !in_end_of_input && in_ch == CH_LF) begin
        // drop the LF of a CRLF pair
        cr_nxt = 1'b0;
      end else begin
        cr_nxt = 1'b0;
        if (in_end_of_input) begin
          if (mode_r == M_STRING) begin
            res[n_res[0]] = make_res(KIND_ERROR, ERR_EOF_STRING, sline_r, scol_r, '0, '0);
            n_res = n_res + 2'd1;
            mode_nxt = M_HALT;
          end else begin
            do_finish = (mode_r != M_IDLE);
            eoi_end   = 1'b1;
          end
        end else if (comment_r) begin
          if (in_ch == CH_LF || in_ch == CH_CR) begin
            comment_nxt = 1'b0;
            line_nxt    = sat_inc(line_r);
            col_nxt     = POS_BITS'(1);
            first_nxt   = 1'b1;
            cr_nxt      = (in_ch == CH_CR);
          end
        end else if (mode_r == M_STRING) begin
          if (in_ch == CH_NUL) begin
            res[n_res[0]] = make_res(KIND_ERROR, ERR_EOF_STRING, sline_r, scol_r, '0, '0);
            n_res = n_res + 2'd1;
            mode_nxt = M_HALT;
          end else if (in_ch == CH_LF || in_ch == CH_CR) begin
            res[n_res[0]] = make_res(KIND_ERROR, ERR_NL_STRING, sline_r, scol_r, '0, '0);
            n_res = n_res + 2'd1;
            mode_nxt = M_HALT;
          end else if (in_ch == CH_QUOTE) begin
            col_nxt = sat_inc(col_r);
            res[n_res[0]] = make_res(KIND_STRING, ERR_NONE, sline_r, scol_r, tlen_r, '0);
            n_res = n_res + 2'd1;
            mode_nxt = M_IDLE;
          end else begin
            col_nxt  = sat_inc(col_r);
            tlen_nxt = sat_inc(tlen_r);
          end
        end else if (mode_r == M_IDLE) begin
          do_start = 1'b1;
        end else if (is_sep(in_ch)) begin
          do_finish = 1'b1;
          do_start  = 1'b1;
        end else begin
          // extend the open identifier or number
          col_nxt  = sat_inc(col_r);
          tlen_nxt = sat_inc(tlen_r);
          if (mode_r == M_NUM_FIRST && dseen_r && mag_r == '0 && in_ch == CH_X) begin
            hex_nxt   = 1'b1;
            dseen_nxt = 1'b0;
            mode_nxt  = M_HEX_SIGN;
          end else if (mode_r == M_HEX_SIGN && (in_ch == CH_PLUS || in_ch == CH_MINUS)) begin
            neg_nxt  = (in_ch == CH_MINUS);
            mode_nxt = M_NUM;
          end else if (mode_r != M_IDENT) begin
            mode_nxt = M_NUM;
            if (dig[4]) begin
              mag_nxt   = mag_digit;
              dseen_nxt = 1'b1;
            end else begin
              nvalid_nxt = 1'b0;
            end
          end
        end
      end
    end

    // Close the open identifier or number
    if (do_finish) begin
      if (mode_r == M_IDENT) begin
        res[n_res[0]] = make_res(KIND_IDENT, ERR_NONE, sline_r, scol_r, tlen_r, '0);
        n_res = n_res + 2'd1;
        mode_nxt = M_IDLE;
      end else if (nvalid_r && (dseen_r || mode_r == M_HEX_SIGN)) begin
        res[n_res[0]] = make_res(KIND_NUMBER, ERR_NONE, sline_r, scol_r, tlen_r, num_val64);
        n_res = n_res + 2'd1;
        mode_nxt = M_IDLE;
      end else begin
        res[n_res[0]] = make_res(KIND_ERROR, ERR_BAD_NUMBER, sline_r, scol_r, '0, '0);
        n_res = n_res + 2'd1;
        mode_nxt  = M_HALT;
        do_start  = 1'b0;
        eoi_end   = 1'b0;
      end
    end

    // End of source after any pending token
    if (eoi_end) begin
      res[n_res[0]] = make_res(KIND_END, ERR_NONE, line_r, col_r, '0, '0);
      n_res = n_res + 2'd1;
      mode_nxt = M_HALT;
    end

    // Open the next token on this byte
    if (do_start) begin
      if (is_space(in_ch)) begin
        if (in_ch == CH_LF || in_ch == CH_CR) begin
          line_nxt  = sat_inc(line_r);
          col_nxt   = POS_BITS'(1);
          first_nxt = 1'b1;
          cr_nxt    = (in_ch == CH_CR);
        end else begin
          col_nxt = sat_inc(col_r);
        end
      end else if (first_r && in_ch == CH_SEMI) begin
        comment_nxt = 1'b1;
      end else if (in_ch == CH_NUL) begin
        res[n_res[0]] = make_res(KIND_END, ERR_NONE, line_r, col_r, '0, '0);
        n_res = n_res + 2'd1;
        mode_nxt = M_HALT;
      end else begin
        sline_nxt = line_r;
        scol_nxt  = col_r;
        col_nxt   = sat_inc(col_r);
        first_nxt = 1'b0;
        tlen_nxt  = '0;
        if (in_ch == CH_COMMA) begin
          res[n_res[0]] = make_res(KIND_COMMA, ERR_NONE, line_r, col_r, '0, '0);
          n_res = n_res + 2'd1;
        end else if (in_ch == CH_COLON) begin
          res[n_res[0]] = make_res(KIND_COLON, ERR_NONE, line_r, col_r, '0, '0);
          n_res = n_res + 2'd1;
        end else if (in_ch == CH_EQ) begin
          res[n_res[0]] = make_res(KIND_EQUALS, ERR_NONE, line_r, col_r, '0, '0);
          n_res = n_res + 2'd1;
        end else if (in_ch == CH_QUOTE) begin
          mode_nxt = M_STRING;
        end else if (is_dec(in_ch) || in_ch == CH_PLUS || in_ch == CH_MINUS) begin
          mode_nxt   = M_NUM_FIRST;
          tlen_nxt   = POS_BITS'(1);
          neg_nxt    = (in_ch == CH_MINUS);
          hex_nxt    = 1'b0;
          nvalid_nxt = 1'b1;
          dseen_nxt  = is_dec(in_ch);
          mag_nxt    = is_dec(in_ch) ? VALUE_BITS'(in_ch - CH_ZERO) : '0;
        end else if (is_alpha(in_ch)) begin
          mode_nxt = M_IDENT;
          tlen_nxt = POS_BITS'(1);
        end else begin
          res[n_res[0]] = make_res(KIND_ERROR, ERR_BAD_START, line_r, col_r, '0, '0);
          n_res = n_res + 2'd1;
          mode_nxt = M_HALT;
        end
      end
    end

    // Flag the final result of this byte
    if (n_res == 2'd1) begin
      res[0].last = 1'b1;
    end else if (n_res == 2'd2) begin
      res[1].last = 1'b1;
    end
  end

  // Scanner state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= M_IDLE;
      first_r   <= 1'b1;
      comment_r <= 1'b0;
      cr_r      <= 1'b0;
      line_r    <= POS_BITS'(1);
      col_r     <= POS_BITS'(1);
      sline_r   <= POS_BITS'(1);
      scol_r    <= POS_BITS'(1);
      tlen_r    <= '0;
      mag_r     <= '0;
      neg_r     <= 1'b0;
      hex_r     <= 1'b0;
      dseen_r   <= 1'b0;
      nvalid_r  <= 1'b1;
    end else begin
      mode_r    <= mode_nxt;
      first_r   <= first_nxt;
      comment_r <= comment_nxt;
      cr_r      <= cr_nxt;
      line_r    <= line_nxt;
      col_r     <= col_nxt;
      sline_r   <= sline_nxt;
      scol_r    <= scol_nxt;
      tlen_r    <= tlen_nxt;
      mag_r     <= mag_nxt;
      neg_r     <= neg_nxt;
      hex_r     <= hex_nxt;
      dseen_r   <= dseen_nxt;
      nvalid_r  <= nvalid_nxt;
    end
  end

  // Result queue pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      tail_r <= tail_r + QPTR'(n_res);
      head_r <= head_r + QPTR'(out_acc);
      cnt_r  <= cnt_r + (QPTR + 1)'(n_res) - (QPTR + 1)'(out_acc);
    end
  end

  // Result queue payload: write the new results at the tail
  always_ff @(posedge clk) begin
    if (n_res != 2'd0) begin
      queue_r[tail_r] <= res[0];
    end
    if (n_res == 2'd2) begin
      queue_r[tail_r + QPTR'(1)] <= res[1];
    end
  end

  assign out_valid        = (cnt_r != '0);
  assign out_kind         = queue_r[head_r].kind;
  assign out_error_code   = queue_r[head_r].error_code;
  assign out_token_line   = queue_r[head_r].token_line;
  assign out_token_col    = queue_r[head_r].token_col;
  assign out_token_length = queue_r[head_r].token_length;
  assign out_number_value = signed'(queue_r[head_r].number_value);
  assign out_last         = queue_r[head_r].last;

endmodule

>>> hw/rtl/ctl_checker.sv
// Port-level checks for the config text lexer, bound to the top level.
module ctl_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [2:0]         out_kind,
  input logic [15:0]        out_token_line,
  input logic [15:0]        out_token_col,
  input logic signed [63:0] out_number_value,
  input logic               out_last
);
  import ctl_pkg::*;

  // Empty result queue right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result presented right after reset");

  // Nothing follows a taken end or error result
  a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && (out_kind == KIND_END || out_kind == KIND_ERROR))
      |=> !out_valid)
    else $error("result after end or error");

  // End and error results close their byte
  a_halt_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == KIND_END || out_kind == KIND_ERROR)) |-> out_last)
    else $error("end or error result not flagged last");

  // Only numbers carry a value
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != KIND_NUMBER) |-> (out_number_value == 64'sd0))
    else $error("nonzero value on a non-number result");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_kind)
      && $stable(out_token_line) && $stable(out_token_col)))
    else $error("stalled result changed");

endmodule

bind config_text_lexer_top ctl_checker u_ctl_checker (.*);

>>> tb/config_text_lexer_top_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for config_text_lexer_top: byte stream in, token requests out.
module config_text_lexer_top_test;
  import ctl_pkg::*;

  localparam int RANDOM_ITEMS  = 750;
  localparam int TAIL_CALM     = 200;
  localparam int HOLD_AT       = 300;
  localparam int HOLD_LEN      = 120;
  localparam int QUIET_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 8;

  typedef enum logic [2:0] {
    LX_IDLE, LX_IDENT, LX_STRING, LX_NUM_FIRST, LX_NUM, LX_HEX_SIGN, LX_HALT
  } lex_mode_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
    logic       drain;
  } src_byte_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_ch = 8'h00;
  logic in_end_of_input = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_kind;
  logic [2:0] out_error_code;
  logic [15:0] out_token_line;
  logic [15:0] out_token_col;
  logic [15:0] out_token_length;
  logic signed [63:0] out_number_value;
  logic out_last;

  config_text_lexer_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_ch            (in_ch),
    .in_end_of_input  (in_end_of_input),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_error_code   (out_error_code),
    .out_token_line   (out_token_line),
    .out_token_col    (out_token_col),
    .out_token_length (out_token_length),
    .out_number_value (out_number_value),
    .out_last         (out_last)
  );

  always #5 clk = ~clk;

  // Pending source bytes and tokens still owed by the block
  src_byte_t byte_q[$];
  result_t   expected_tokens[$];
  result_t   step_tokens[$];
  int bytes_queued = 0;
  int bytes_taken = 0;
  int tokens_seen = 0;
  int errors = 0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int quiet = 0;
  logic gen_line_head = 1'b1;

  // Scanner state, at its reset values
  lex_mode_e   mode = LX_IDLE;
  logic        at_line_head = 1'b1;
  logic        comment_on = 1'b0;
  logic        cr_seen = 1'b0;
  logic [15:0] cur_line = 16'd1;
  logic [15:0] cur_col = 16'd1;
  logic [15:0] tok_line = 16'd1;
  logic [15:0] tok_col = 16'd1;
  logic [15:0] tok_len = 16'd0;
  logic [63:0] mag = 64'd0;
  logic        neg = 1'b0;
  logic        hexmode = 1'b0;
  logic        have_digit = 1'b0;
  logic        num_ok = 1'b1;

  function automatic logic blank_ch(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic letter_ch(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic digit_ch(input logic [7:0] c);
    return c >= CH_ZERO && c <= 8'h39;
  endfunction

  function automatic logic stop_ch(input logic [7:0] c);
    return c == CH_RPAR || c == CH_COMMA || c == CH_EQ || c == CH_COLON || blank_ch(c);
  endfunction

  function automatic logic [15:0] bump16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic void post_token(input logic [2:0] kind, input logic [2:0] err,
                                     input logic [15:0] line, input logic [15:0] col,
                                     input logic [15:0] len, input logic [63:0] val);
    result_t r;
    r.kind = kind;
    r.error_code = err;
    r.token_line = line;
    r.token_col = col;
    r.token_length = len;
    r.number_value = val;
    r.last = 1'b0;
    step_tokens = {step_tokens, r};
  endfunction

  function automatic void take_blank(input logic [7:0] c);
    if (c == CH_LF || c == CH_CR) begin
      cur_line = bump16(cur_line);
      cur_col = 16'd1;
      at_line_head = 1'b1;
      cr_seen = (c == CH_CR);
    end else begin
      cur_col = bump16(cur_col);
    end
  endfunction

  // Accumulate one digit, clamping the magnitude at 2^63
  function automatic void add_digit(input logic [7:0] c);
    logic [63:0] radix;
    logic [63:0] d;
    logic ok;
    radix = hexmode ? 64'd16 : 64'd10;
    ok = 1'b1;
    d = 64'd0;
    if (digit_ch(c)) begin
      d = {56'd0, c} - 64'd48;
    end else if (hexmode && c >= 8'h61 && c <= 8'h66) begin
      d = {56'd0, c} - 64'd87;
    end else if (hexmode && c >= 8'h41 && c <= 8'h46) begin
      d = {56'd0, c} - 64'd55;
    end else begin
      ok = 1'b0;
    end
    if (!ok) begin
      num_ok = 1'b0;
    end else begin
      if (mag > (VAL_CAP - d) / radix) mag = VAL_CAP;
      else mag = mag * radix + d;
      have_digit = 1'b1;
    end
  endfunction

  function automatic void absorb_digit(input logic [7:0] c);
    if (mode == LX_NUM_FIRST) begin
      mode = LX_NUM;
      if (have_digit && mag == 64'd0 && c == CH_X) begin
        hexmode = 1'b1;
        have_digit = 1'b0;
        mode = LX_HEX_SIGN;
        return;
      end
    end else if (mode == LX_HEX_SIGN) begin
      mode = LX_NUM;
      if (c == CH_PLUS || c == CH_MINUS) begin
        neg = (c == CH_MINUS);
        return;
      end
    end
    add_digit(c);
  endfunction

  function automatic void close_token();
    logic [63:0] v;
    if (mode == LX_IDENT) begin
      post_token(KIND_IDENT, ERR_NONE, tok_line, tok_col, tok_len, 64'd0);
    end else if (num_ok && (have_digit || mode == LX_HEX_SIGN)) begin
      if (neg) v = 64'd0 - mag;
      else v = (mag < VAL_CAP) ? mag : VAL_CAP - 64'd1;
      post_token(KIND_NUMBER, ERR_NONE, tok_line, tok_col, tok_len, v);
    end else begin
      post_token(KIND_ERROR, ERR_BAD_NUMBER, tok_line, tok_col, 16'd0, 64'd0);
      mode = LX_HALT;
      return;
    end
    mode = LX_IDLE;
  endfunction

  function automatic void open_token(input logic [7:0] c);
    if (blank_ch(c)) begin
      take_blank(c);
      return;
    end
    if (at_line_head && c == CH_SEMI) begin
      comment_on = 1'b1;
      return;
    end
    if (c == CH_NUL) begin
      post_token(KIND_END, ERR_NONE, cur_line, cur_col, 16'd0, 64'd0);
      mode = LX_HALT;
      return;
    end
    tok_line = cur_line;
    tok_col = cur_col;
    cur_col = bump16(cur_col);
    at_line_head = 1'b0;
    tok_len = 16'd0;
    if (c == CH_COMMA) begin
      post_token(KIND_COMMA, ERR_NONE, tok_line, tok_col, 16'd0, 64'd0);
    end else if (c == CH_COLON) begin
      post_token(KIND_COLON, ERR_NONE, tok_line, tok_col, 16'd0, 64'd0);
    end else if (c == CH_EQ) begin
      post_token(KIND_EQUALS, ERR_NONE, tok_line, tok_col, 16'd0, 64'd0);
    end else if (c == CH_QUOTE) begin
      mode = LX_STRING;
    end else if (digit_ch(c) || c == CH_PLUS || c == CH_MINUS) begin
      mode = LX_NUM_FIRST;
      tok_len = 16'd1;
      mag = 64'd0;
      neg = (c == CH_MINUS);
      hexmode = 1'b0;
      have_digit = 1'b0;
      num_ok = 1'b1;
      if (digit_ch(c)) add_digit(c);
    end else if (letter_ch(c)) begin
      mode = LX_IDENT;
      tok_len = 16'd1;
    end else begin
      post_token(KIND_ERROR, ERR_BAD_START, tok_line, tok_col, 16'd0, 64'd0);
      mode = LX_HALT;
    end
  endfunction

  // Advance the scanner by one accepted byte and queue the tokens it yields
  task automatic scan_byte(input logic [7:0] c, input logic eoi);
    result_t r;
    if (mode == LX_HALT) return;
    if (cr_seen) begin
      cr_seen = 1'b0;
      if (!eoi && c == CH_LF) return;
    end
    if (eoi) begin
      if (mode == LX_STRING) begin
        post_token(KIND_ERROR, ERR_EOF_STRING, tok_line, tok_col, 16'd0, 64'd0);
      end else begin
        if (mode != LX_IDLE) close_token();
        if (mode != LX_HALT) post_token(KIND_END, ERR_NONE, cur_line, cur_col, 16'd0, 64'd0);
      end
      mode = LX_HALT;
    end else if (comment_on) begin
      if (c == CH_LF || c == CH_CR) begin
        comment_on = 1'b0;
        take_blank(c);
      end
    end else if (mode == LX_STRING) begin
      if (c == CH_NUL) begin
        post_token(KIND_ERROR, ERR_EOF_STRING, tok_line, tok_col, 16'd0, 64'd0);
        mode = LX_HALT;
      end else if (c == CH_LF || c == CH_CR) begin
        post_token(KIND_ERROR, ERR_NL_STRING, tok_line, tok_col, 16'd0, 64'd0);
        mode = LX_HALT;
      end else if (c == CH_QUOTE) begin
        cur_col = bump16(cur_col);
        post_token(KIND_STRING, ERR_NONE, tok_line, tok_col, tok_len, 64'd0);
        mode = LX_IDLE;
      end else begin
        cur_col = bump16(cur_col);
        tok_len = bump16(tok_len);
      end
    end else if (mode == LX_IDLE) begin
      open_token(c);
    end else if (stop_ch(c)) begin
      close_token();
      if (mode != LX_HALT) open_token(c);
    end else begin
      cur_col = bump16(cur_col);
      tok_len = bump16(tok_len);
      if (mode != LX_IDENT) absorb_digit(c);
    end
    // Flag the final token of this byte
    for (int i = 0; i < step_tokens.size(); i++) begin
      r = step_tokens[i];
      r.last = (i == step_tokens.size() - 1);
      expected_tokens = {expected_tokens, r};
    end
    step_tokens.delete();
  endtask

  task automatic note_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    errors++;
    $display("mismatch %s at token %0d: got %0h want %0h", what, tokens_seen, got, want);
  endtask

  task automatic check_token();
    result_t want;
    if (expected_tokens.size() == 0) begin
      note_mismatch("unexpected token, kind", 64'(out_kind), 64'd0);
      return;
    end
    want = expected_tokens.pop_front();
    if (out_kind !== want.kind) note_mismatch("kind", 64'(out_kind), 64'(want.kind));
    if (out_error_code !== want.error_code)
      note_mismatch("error_code", 64'(out_error_code), 64'(want.error_code));
    if (out_token_line !== want.token_line)
      note_mismatch("token_line", 64'(out_token_line), 64'(want.token_line));
    if (out_token_col !== want.token_col)
      note_mismatch("token_col", 64'(out_token_col), 64'(want.token_col));
    if (out_token_length !== want.token_length)
      note_mismatch("token_length", 64'(out_token_length), 64'(want.token_length));
    if (out_number_value !== want.number_value)
      note_mismatch("number_value", out_number_value, want.number_value);
    if (out_last !== want.last) note_mismatch("last", 64'(out_last), 64'(want.last));
  endtask

  task automatic push_ch(input logic [7:0] b);
    src_byte_t e;
    e = '{ch: b, eoi: 1'b0, drain: 1'b0};
    byte_q = {byte_q, e};
    bytes_queued++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_ch(s[i]);
  endtask

  task automatic push_eoi();
    src_byte_t e;
    e = '{ch: 8'($urandom_range(0, 255)), eoi: 1'b1, drain: 1'b0};
    byte_q = {byte_q, e};
    bytes_queued++;
  endtask

  // Hold the sender until every owed token has come back
  task automatic push_drain();
    src_byte_t e;
    e = '{ch: 8'h00, eoi: 1'b0, drain: 1'b1};
    byte_q = {byte_q, e};
  endtask

  task automatic push_newline();
    int k;
    k = $urandom_range(0, 2);
    if (k == 0) begin
      push_ch(CH_LF);
    end else begin
      push_ch(CH_CR);
      if (k == 2) push_ch(CH_LF);
    end
    gen_line_head = 1'b1;
  endtask

  // Close an identifier or number with some separator
  task automatic push_break();
    int k;
    k = $urandom_range(0, 8);
    case (k)
      0: push_ch(8'h20);
      1: push_ch(8'h09);
      2: push_ch(8'h0B);
      3: push_ch(8'h0C);
      4: push_ch(CH_COMMA);
      5: push_ch(CH_COLON);
      6: push_ch(CH_EQ);
      default: push_newline();
    endcase
  endtask

  // Hold reset for the opening cycles
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Present source requests; hold a stalled request steady
  always @(posedge clk) begin : feed
    src_byte_t nxt;
    logic take;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      take = in_valid && !in_stall;
      if (take) begin
        scan_byte(in_ch, in_end_of_input);
        bytes_taken++;
      end
      if (!in_valid || take) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (byte_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (byte_q[0].drain) begin
          if (expected_tokens.size() == 0) void'(byte_q.pop_front());
          in_valid <= 1'b0;
        end else if (byte_q.size() > TAIL_CALM && hold_left == 0 &&
                     (bytes_taken / 64) % 4 != 3 && $urandom_range(0, 15) == 0) begin
          gap_left = $urandom_range(0, 8);
          in_valid <= 1'b0;
        end else begin
          nxt = byte_q.pop_front();
          in_valid <= 1'b1;
          in_ch <= nxt.ch;
          in_end_of_input <= nxt.eoi;
        end
      end
    end
  end

  // Accept token requests and check them; stall in bursts and once for a long hold
  always @(posedge clk) begin : sink
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        check_token();
        tokens_seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && bytes_taken >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN - 1;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (byte_q.size() > TAIL_CALM && (bytes_taken / 64) % 4 != 2 &&
                   $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(0, 8);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Abort when neither channel moves for too long
  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Build the source text, then wait for the block to drain
  initial begin : stimulus
    int r;
    int n;
    int s;
    int v;
    logic [7:0] b;
    bit drain_a;
    bit drain_b;
    drain_a = 1'b0;
    drain_b = 1'b0;

    // Directed: comment on line one ended by CRLF
    push_text(";");
    push_ch(CH_CR);
    push_ch(CH_LF);
    // Identifier holding NUL and 0xFF, then comma
    push_text("q");
    push_ch(CH_NUL);
    push_ch(8'hFF);
    push_ch(CH_COMMA);
    // Bare hex prefix, empty string, signed decimal, tab, VT, FF and space
    push_text("0x=");
    push_ch(CH_QUOTE);
    push_ch(CH_QUOTE);
    push_text("-7:");
    push_ch(8'h09);
    push_ch(8'h0B);
    push_ch(8'h0C);
    push_text(" ");
    // LF then a lone CR, then negative hex
    push_ch(CH_LF);
    push_ch(CH_CR);
    push_text("0x-A");
    push_ch(CH_LF);
    gen_line_head = 1'b1;

    // Random well-formed text
    while (bytes_queued < RANDOM_ITEMS) begin
      if (!drain_a && bytes_queued > 400) begin
        drain_a = 1'b1;
        push_drain();
      end
      if (!drain_b && bytes_queued > 620) begin
        drain_b = 1'b1;
        push_drain();
      end
      r = $urandom_range(0, 19);
      case (r)
        0, 1, 2, 3: begin
          b = 8'($urandom_range(0, 25)) + (($urandom_range(0, 1) == 0) ? 8'h41 : 8'h61);
          push_ch(b);
          n = $urandom_range(0, 8);
          repeat (n) begin
            b = 8'($urandom_range(0, 255));
            while (stop_ch(b)) b = 8'($urandom_range(0, 255));
            push_ch(b);
          end
          gen_line_head = 1'b0;
          push_break();
        end
        4, 5, 6: begin
          s = $urandom_range(0, 2);
          if (s == 1) push_ch(CH_PLUS);
          if (s == 2) push_ch(CH_MINUS);
          n = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 24) : $urandom_range(1, 5);
          repeat (n) push_ch(CH_ZERO + 8'($urandom_range(0, 9)));
          gen_line_head = 1'b0;
          push_break();
        end
        7, 8: begin
          push_text("0x");
          s = $urandom_range(0, 2);
          if (s == 1) push_ch(CH_PLUS);
          if (s == 2) push_ch(CH_MINUS);
          n = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 20) : $urandom_range(0, 4);
          if (s != 0 && n == 0) n = 1;
          repeat (n) begin
            v = $urandom_range(0, 15);
            if (v < 10) push_ch(CH_ZERO + 8'(v));
            else push_ch(8'(v - 10) + (($urandom_range(0, 1) == 0) ? 8'h41 : 8'h61));
          end
          gen_line_head = 1'b0;
          push_break();
        end
        9, 10: begin
          push_ch(CH_QUOTE);
          n = $urandom_range(0, 10);
          repeat (n) begin
            b = 8'($urandom_range(0, 255));
            while (b == CH_NUL || b == CH_CR || b == CH_LF || b == CH_QUOTE)
              b = 8'($urandom_range(0, 255));
            push_ch(b);
          end
          push_ch(CH_QUOTE);
          gen_line_head = 1'b0;
        end
        11: begin
          push_ch(CH_COMMA);
          gen_line_head = 1'b0;
        end
        12: begin
          push_ch(CH_COLON);
          gen_line_head = 1'b0;
        end
        13: begin
          push_ch(CH_EQ);
          gen_line_head = 1'b0;
        end
        14, 15: push_ch(($urandom_range(0, 1) == 0) ? 8'h20 : 8'h09);
        16, 17: push_newline();
        default: begin
          if (gen_line_head) begin
            if ($urandom_range(0, 1) == 0) push_ch(8'h20);
            push_ch(CH_SEMI);
            n = $urandom_range(0, 8);
            repeat (n) begin
              b = 8'($urandom_range(0, 255));
              while (b == CH_CR || b == CH_LF) b = 8'($urandom_range(0, 255));
              push_ch(b);
            end
          end
          push_newline();
        end
      endcase
    end

    // One more assignment before the closing token
    push_text("z=5 ");

    // Finish the source with one randomly chosen end or error
    r = $urandom_range(0, 12);
    case (r)
      0: push_eoi();
      1: begin
        push_text("ab");
        push_eoi();
      end
      2: begin
        push_text("-12");
        push_eoi();
      end
      3: push_ch(CH_NUL);
      4: begin
        push_ch(CH_QUOTE);
        push_text("xy");
        push_eoi();
      end
      5: begin
        push_ch(CH_QUOTE);
        push_text("x");
        push_ch(CH_NUL);
      end
      6: begin
        push_ch(CH_QUOTE);
        push_ch(CH_CR);
      end
      7: begin
        push_ch(CH_QUOTE);
        push_ch(CH_LF);
      end
      8: push_ch(CH_RPAR);
      9: begin
        b = 8'($urandom_range(0, 255));
        while (blank_ch(b) || digit_ch(b) || letter_ch(b) || b == CH_NUL ||
               b == CH_COMMA || b == CH_COLON || b == CH_EQ || b == CH_QUOTE ||
               b == CH_PLUS || b == CH_MINUS)
          b = 8'($urandom_range(0, 255));
        push_ch(b);
      end
      10: begin
        if ($urandom_range(0, 1) == 0) push_text("12a ");
        else push_text("+,");
      end
      11: begin
        push_ch(CH_LF);
        push_text(";zz");
        push_eoi();
      end
      default: begin
        push_text("0x-");
        push_eoi();
      end
    endcase

    // Trailing bytes after the halt must give nothing
    push_eoi();
    repeat (23) begin
      if ($urandom_range(0, 1) == 0) push_eoi();
      else push_ch(8'($urandom_range(0, 255)));
    end

    while (bytes_taken < bytes_queued) @(posedge clk);
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && expected_tokens.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
